>>> hdl/abe_pkg.sv
package abe_pkg;

	localparam int IDX_W         = 12;
	localparam int SIZE_W        = 13;
	localparam int BITS_DEF      = 4096;
	localparam int WORD_BITS_DEF = 64;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd4096;

	typedef enum logic [2:0] {
		OP_SET      = 3'd0,
		OP_CLR      = 3'd1,
		OP_RD       = 3'd2,
		OP_FIND_CLR = 3'd3,
		OP_FIND_SET = 3'd4
	} req_op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD,
		ST_EXEC,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [2:0]       req_type;
		logic [IDX_W-1:0] bit_index;
	} req_t;

	typedef struct packed {
		logic             bit_value;
		logic             found;
		logic [IDX_W-1:0] found_index;
	} rsp_t;

endpackage

>>> hdl/abe_mem.sv
module abe_mem #(
	parameter int WORDS = 64,
	parameter int WIDTH = 64,
	parameter int AW    = 6
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data
);

	logic [WIDTH-1:0] mem [WORDS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> hdl/abe_ctrl.sv
module abe_ctrl #(
	parameter int BITS      = 4096,
	parameter int WORD_BITS = 64,
	parameter int NWORDS    = 64,
	parameter int AW        = 6
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [abe_pkg::SIZE_W-1:0] cfg_wdata,
	input  logic                    req_valid,
	output logic                    req_ready,
	input  abe_pkg::req_t           req,
	output logic                    rsp_valid,
	input  logic                    rsp_ready,
	output abe_pkg::rsp_t           rsp,
	output logic                    rd_en,
	output logic [AW-1:0]           rd_addr,
	input  logic [WORD_BITS-1:0]    rd_data,
	output logic                    wr_en,
	output logic [AW-1:0]           wr_addr,
	output logic [WORD_BITS-1:0]    wr_data
);

	import abe_pkg::*;

	localparam int OFF_W  = $clog2(WORD_BITS);
	localparam int LIM_W  = $clog2(BITS + 1);
	localparam int POS_W  = (LIM_W > SIZE_W) ? LIM_W : SIZE_W;
	// exact reciprocal for splitting a 12-bit index into word and offset
	localparam int SH     = IDX_W + OFF_W;
	localparam int RCP_W  = IDX_W + 1;
	localparam int RECIP  = ((2 ** SH) + WORD_BITS - 1) / WORD_BITS;
	localparam int PROD_W = IDX_W + RCP_W;
	localparam int Q_W    = PROD_W - SH;

	function automatic logic [OFF_W-1:0] first_one(input logic [WORD_BITS-1:0] v);
		logic [OFF_W-1:0] pos;
		pos = '0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (v[b]) pos = OFF_W'(b);
		end
		return pos;
	endfunction

	state_t               state_q, state_n;
	logic [SIZE_W-1:0]    size_q;
	logic [AW-1:0]        clr_q;
	logic                 rsp_valid_q;
	rsp_t                 rsp_q;
	rsp_t                 res_q, res_n;
	logic                 res_ld;
	logic [2:0]           op_q;
	logic [IDX_W-1:0]     idx_q;
	logic [PROD_W-1:0]    prod_q;
	logic [OFF_W-1:0]     off_q;
	logic [AW-1:0]        cw_q;
	logic [POS_W-1:0]     base_q;
	logic                 first_q;

	logic [POS_W-1:0]     lim;
	logic [Q_W-1:0]       quo;
	logic [POS_W-1:0]     qbase;
	logic                 in_range;
	logic                 is_srch;
	logic                 clr_last;
	logic [POS_W-1:0]     rem;
	logic [WORD_BITS-1:0] cand;
	logic                 hit;
	logic                 last;
	logic [POS_W:0]       base_nx;
	logic [POS_W-1:0]     fidx;

	assign lim = (POS_W'(size_q) > POS_W'(BITS)) ? POS_W'(BITS) : POS_W'(size_q);
	assign quo = prod_q[PROD_W-1:SH];
	assign qbase = POS_W'(quo * WORD_BITS);
	assign in_range = POS_W'(idx_q) < lim;
	assign is_srch = (op_q inside {OP_FIND_CLR, OP_FIND_SET});
	assign clr_last = (clr_q == AW'(NWORDS - 1));

	// scan datapath: masks for start offset and limit, then first hit
	assign rem = lim - base_q;
	always_comb begin
		for (int b = 0; b < WORD_BITS; b++) begin
			cand[b] = ((op_q == OP_FIND_SET) ? rd_data[b] : !rd_data[b])
				&& (!first_q || (OFF_W'(b) >= off_q))
				&& (POS_W'(b) < rem);
		end
	end
	assign hit = |cand;
	assign base_nx = {1'b0, base_q} + (POS_W + 1)'(WORD_BITS);
	assign last = base_nx >= {1'b0, lim};
	assign fidx = base_q + POS_W'(first_one(cand));

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_CLEAR: if (clr_last) state_n = ST_IDLE;
			ST_IDLE:  if (req_valid) state_n = ST_RD;
			ST_RD: begin
				if (!in_range || op_q > OP_FIND_SET) state_n = ST_DONE;
				else if (is_srch) state_n = ST_SCAN;
				else state_n = ST_EXEC;
			end
			ST_EXEC:  state_n = ST_DONE;
			ST_SCAN:  if (hit || last) state_n = ST_DONE;
			ST_DONE:  if (!rsp_valid_q || rsp_ready) state_n = ST_IDLE;
			default:  state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = AW'(quo);
		wr_en     = 1'b0;
		wr_addr   = cw_q;
		wr_data   = rd_data;
		res_ld    = 1'b0;
		res_n     = '0;
		case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
			end
			ST_IDLE: req_ready = 1'b1;
			ST_RD: begin
				if (!in_range || op_q > OP_FIND_SET) res_ld = 1'b1;
				else rd_en = 1'b1;
			end
			ST_EXEC: begin
				res_ld = 1'b1;
				if (op_q == OP_RD) begin
					res_n.bit_value = rd_data[off_q];
				end else begin
					wr_en = 1'b1;
					wr_data[off_q] = (op_q == OP_SET);
				end
			end
			ST_SCAN: begin
				if (hit) begin
					res_ld = 1'b1;
					res_n.found = 1'b1;
					res_n.found_index = fidx[IDX_W-1:0];
				end else if (last) begin
					res_ld = 1'b1;
				end else begin
					rd_en   = 1'b1;
					rd_addr = cw_q + AW'(1);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			size_q      <= SIZE_RESET;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cfg_we) size_q <= cfg_wdata;
			if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);
			if (state_q == ST_DONE && (!rsp_valid_q || rsp_ready)) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			op_q   <= req.req_type;
			idx_q  <= req.bit_index;
			prod_q <= PROD_W'(req.bit_index) * PROD_W'(RECIP);
		end
		if (state_q == ST_RD) begin
			cw_q    <= AW'(quo);
			base_q  <= qbase;
			off_q   <= OFF_W'(POS_W'(idx_q) - qbase);
			first_q <= 1'b1;
		end
		if (state_q == ST_SCAN) begin
			cw_q    <= cw_q + AW'(1);
			base_q  <= base_nx[POS_W-1:0];
			first_q <= 1'b0;
		end
		if (res_ld) res_q <= res_n;
		if (state_q == ST_DONE && (!rsp_valid_q || rsp_ready)) rsp_q <= res_q;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_accept_to_rd: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> state_q == ST_RD)
		else $error("accepted item did not start a memory read");
	a_scan_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> !wr_en)
		else $error("memory write during a search");
	a_scan_below_lim: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> base_q < lim)
		else $error("search word beyond the size limit");
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && wr_en && rd_addr == wr_addr))
		else $error("read and write of the same word in one cycle");

endmodule

>>> hdl/allocation_bitmap_engine.sv
// Allocation bit map: set, clear or read one bit, or search upward from a
// start position for the first clear or first set bit below the size limit.
// Request channel req/req_valid/req_ready carries one item per request;
// every request gives exactly one item on rsp/rsp_valid/rsp_ready.
// cfg_we/cfg_wdata write size_in_bits at any edge; write it only while idle.
// Reset: size returns to 4096 and a clearing pass writes zero to every one of
// the NWORDS map words (64 by default), one word per cycle; req_ready stays
// low until it is done.
// Each accepted item goes through ST_RD; set, clear and read in range then
// pass ST_EXEC (read-modify-write), a search passes ST_SCAN once per word
// scanned (1 to NWORDS), and an out-of-range index or unused code goes
// straight to ST_DONE, from where the result is registered to rsp_valid.
// The search speed is set by the single map read port: one word a cycle.
// The result sits in an output register; the next item is accepted while
// it waits. If the receiver stalls, the following result waits in a staging
// register and the block takes no further item until the output frees.
module allocation_bitmap_engine #(
	parameter int BITS      = abe_pkg::BITS_DEF,
	parameter int WORD_BITS = abe_pkg::WORD_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [abe_pkg::SIZE_W-1:0] cfg_wdata,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  abe_pkg::req_t              req,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output abe_pkg::rsp_t              rsp
);

	import abe_pkg::*;

	// map geometry
	localparam int NWORDS = (BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;

	logic                 rd_en;
	logic [AW-1:0]        rd_addr;
	logic [WORD_BITS-1:0] rd_data;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [WORD_BITS-1:0] wr_data;

	// sequencer: index split, read-modify-write and word-by-word scan
	abe_ctrl #(
		.BITS      (BITS),
		.WORD_BITS (WORD_BITS),
		.NWORDS    (NWORDS),
		.AW        (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	// bit map words, registered read
	abe_mem #(
		.WORDS (NWORDS),
		.WIDTH (WORD_BITS),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

endmodule

>>> tb/allocation_bitmap_engine_tb.sv
`timescale 1ns / 1ps

module allocation_bitmap_engine_tb;

	import abe_pkg::*;

	// Request codes with no operation behind them (block must answer all zero)
	localparam logic [2:0] REQ_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] REQ_UNUSED_LAST  = 3'd7;

	// Bound on the longest search, which scans every map word
	localparam int SCAN_LATENCY  = 2 + BITS_DEF / WORD_BITS_DEF;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_ITEMS   = 190;

	logic              clk;
	logic              arst_n    = 1'b0;
	logic              cfg_we    = 1'b0;
	logic [SIZE_W-1:0] cfg_wdata = '0;
	logic              req_valid = 1'b0;
	logic              req_ready;
	req_t              req       = '0;
	logic              rsp_valid;
	logic              rsp_ready = 1'b0;
	rsp_t              rsp;

	allocation_bitmap_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// Shadow of the block: the bit map and the size register
	logic [BITS_DEF-1:0] map_bits    = '0;
	logic [SIZE_W-1:0]   size_shadow = SIZE_RESET;

	// Results owed by the block, oldest first
	rsp_t pending_rsps[$];
	int   mismatch_count = 0;

	// Idle control for the sender task and the receiver process, set by the tests
	bit send_gapless = 1'b0;
	bit recv_gapless = 1'b0;
	int recv_hold    = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop in case the block hangs
	initial begin
		#20_000_000;
		$display("** allocation_bitmap_engine: FAILED **");
		$finish;
	end

	// Sizes above the map depth clamp to the depth
	function automatic int active_limit();
		return (size_shadow > BITS_DEF) ? BITS_DEF : int'(size_shadow);
	endfunction

	// Applies one request to the shadow map and returns the answer it owes
	function automatic rsp_t bitmap_predict(input req_t item);
		int   lim;
		int   p;
		logic want;
		rsp_t res;
		lim  = active_limit();
		res  = '0;
		want = (item.req_type == OP_FIND_SET);
		case (item.req_type)
			OP_SET: begin
				if (item.bit_index < lim)
					map_bits[item.bit_index] = 1'b1;
			end
			OP_CLR: begin
				if (item.bit_index < lim)
					map_bits[item.bit_index] = 1'b0;
			end
			OP_RD: begin
				if (item.bit_index < lim)
					res.bit_value = map_bits[item.bit_index];
			end
			OP_FIND_CLR, OP_FIND_SET: begin
				// upward scan, first match wins; nothing at or past the limit
				for (p = item.bit_index; p < lim && !res.found; p++) begin
					if (map_bits[p] == want) begin
						res.found       = 1'b1;
						res.found_index = p[IDX_W-1:0];
					end
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	function automatic req_t make_req(input logic [2:0] op, input int idx);
		req_t r;
		r.req_type  = op;
		r.bit_index = idx[IDX_W-1:0];
		return r;
	endfunction

	// Random request: half around a hot window so bits pile up and searches
	// have something to find, some anywhere, some right at the size limit
	function automatic req_t random_request(input int hot_base);
		int         sel;
		int         idx;
		logic [2:0] op;
		sel = $urandom_range(0, 99);
		if (sel < 30)
			op = OP_SET;
		else if (sel < 50)
			op = OP_CLR;
		else if (sel < 65)
			op = OP_RD;
		else if (sel < 80)
			op = OP_FIND_CLR;
		else if (sel < 95)
			op = OP_FIND_SET;
		else
			op = 3'($urandom_range(REQ_UNUSED_LAST, REQ_UNUSED_FIRST));
		sel = $urandom_range(0, 9);
		if (sel < 5)
			idx = hot_base + $urandom_range(0, 255);
		else if (sel < 8)
			idx = $urandom_range(0, BITS_DEF - 1);
		else
			idx = active_limit() + $urandom_range(0, 3) - 2;
		return make_req(op, idx);
	endfunction

	// Sends one item; valid stays up after the accept so a gapless follower
	// never drops it within the same step
	task automatic send_item(input req_t item);
		int gap;
		gap = send_gapless ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req       <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		pending_rsps.push_back(bitmap_predict(item));
	endtask

	// Sender goes quiet until every owed result is back, then a short settle
	task automatic wait_for_results(input int settle);
		req_valid <= 1'b0;
		while (pending_rsps.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// Size register is only touched with the block idle
	task automatic write_size(input logic [SIZE_W-1:0] value);
		wait_for_results(SETTLE_CYCLES);
		cfg_wdata <= value;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we      <= 1'b0;
		size_shadow = value;
	endtask

	// Receiver: random stall before each item, or a long hold when asked
	initial begin : receiver
		int stall;
		@(posedge clk);
		forever begin
			if (recv_hold > 0) begin
				stall     = recv_hold;
				recv_hold = 0;
			end else begin
				stall = recv_gapless ? 0 : $urandom_range(0, 10);
			end
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!(rsp_valid && rsp_ready));
		end
	end

	task automatic report_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// Every accepted result is checked against the oldest expectation
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_rsps.size() == 0) begin
				$display("%0t: unexpected result, expected none got %h", $time, rsp);
				mismatch_count++;
			end else begin
				want = pending_rsps.pop_front();
				if ($isunknown(rsp)) begin
					$display("%0t: result has X, expected %h got %h", $time, want, rsp);
					mismatch_count++;
				end else begin
					report_field("bit_value", want.bit_value, rsp.bit_value);
					report_field("found", want.found, rsp.found);
					report_field("found_index", want.found_index, rsp.found_index);
				end
			end
		end
	end

	// Every operation at the map edges and across a word boundary, full size
	task automatic test_directed_ops();
		send_item(make_req(OP_RD, 0));
		send_item(make_req(OP_FIND_SET, 0));          // empty map: scans all, none
		send_item(make_req(OP_FIND_CLR, BITS_DEF - 1));  // last position
		send_item(make_req(OP_SET, 0));
		send_item(make_req(OP_SET, WORD_BITS_DEF - 1));
		send_item(make_req(OP_SET, WORD_BITS_DEF));
		send_item(make_req(OP_SET, BITS_DEF - 1));
		send_item(make_req(OP_RD, BITS_DEF - 1));
		send_item(make_req(OP_FIND_SET, 1));
		send_item(make_req(OP_FIND_SET, WORD_BITS_DEF + 1));  // long hop to the top
		send_item(make_req(OP_FIND_CLR, WORD_BITS_DEF - 1)); // run across the boundary
		send_item(make_req(OP_CLR, WORD_BITS_DEF - 1));
		send_item(make_req(OP_FIND_SET, 1));
		send_item(make_req(REQ_UNUSED_FIRST, BITS_DEF - 1));
		send_item(make_req(REQ_UNUSED_LAST, 0));
		send_item(make_req(OP_RD, 0));
	endtask

	// Size extremes: zero, above the depth, one word, and back to full
	task automatic test_size_extremes();
		write_size('0);
		send_item(make_req(OP_SET, 5));               // beyond limit, ignored
		send_item(make_req(OP_RD, 0));                // set bit, but past the limit
		send_item(make_req(OP_FIND_CLR, 0));
		write_size({SIZE_W{1'b1}});
		send_item(make_req(OP_FIND_SET, 100));        // clamps at the depth
		write_size(SIZE_W'(WORD_BITS_DEF));
		send_item(make_req(OP_SET, WORD_BITS_DEF));
		send_item(make_req(OP_RD, WORD_BITS_DEF));
		send_item(make_req(OP_FIND_SET, 1));          // nothing left below the limit
		send_item(make_req(OP_FIND_CLR, WORD_BITS_DEF)); // start at the limit
		write_size(SIZE_RESET);
		send_item(make_req(OP_RD, WORD_BITS_DEF));
	endtask

	// Receiver holds off while the sender keeps pushing, so the result
	// register and staging fill and req_ready must drop
	task automatic test_backpressure();
		int i;
		int hot_base;
		wait_for_results(SETTLE_CYCLES);
		hot_base     = $urandom_range(0, BITS_DEF - 1);
		send_gapless = 1'b1;
		recv_hold    = 300;
		for (i = 0; i < 30; i++)
			send_item(random_request(hot_base));
		send_gapless = 1'b0;
		wait_for_results(SETTLE_CYCLES);
	endtask

	// Random traffic over several sizes. Runs of consecutive sets or clears
	// followed by a search from just below the run make the scans travel;
	// loose random requests in between break the pattern up.
	task automatic test_random_traffic();
		logic [SIZE_W-1:0] sizes[8];
		int                phase;
		int                count;
		int                quota;
		int                base;
		int                run_len;
		int                i;
		logic [2:0]        run_op;
		sizes[0] = SIZE_RESET;
		sizes[1] = {SIZE_W{1'b1}};
		sizes[2] = SIZE_W'($urandom_range(1, BITS_DEF - 1));
		sizes[3] = SIZE_W'(WORD_BITS_DEF + 1);
		sizes[4] = SIZE_W'(BITS_DEF - 1);
		sizes[5] = SIZE_W'($urandom_range(BITS_DEF + 1, 8191));
		sizes[6] = SIZE_W'(1);
		sizes[7] = SIZE_RESET;
		for (phase = 0; phase < 8; phase++) begin
			write_size(sizes[phase]);
			quota = (sizes[phase] == 1) ? 40 : PHASE_ITEMS;
			// one phase with neither side idling
			send_gapless = (phase == 4);
			recv_gapless = (phase == 4);
			count = 0;
			base  = $urandom_range(0, BITS_DEF - 1);
			while (count < quota) begin
				if ($urandom_range(0, 9) < 4) begin
					run_len = $urandom_range(4, 48);
					run_op  = ($urandom_range(0, 2) != 0) ? OP_SET : OP_CLR;
					for (i = 0; i < run_len; i++)
						send_item(make_req(run_op, base + i));
					send_item(make_req(run_op == OP_SET ? OP_FIND_CLR : OP_FIND_SET,
						base - $urandom_range(0, 8)));
					count += run_len + 1;
					base  = $urandom_range(0, BITS_DEF - 1);
				end else begin
					send_item(random_request(base));
					count++;
				end
			end
		end
		send_gapless = 1'b0;
		recv_gapless = 1'b0;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		// first item waits out the clearing pass through req_ready
		test_directed_ops();
		test_size_extremes();
		test_backpressure();
		test_random_traffic();
		wait_for_results(SCAN_LATENCY + SETTLE_CYCLES);
		if (mismatch_count == 0 && pending_rsps.size() == 0)
			$display("** allocation_bitmap_engine: PASSED **");
		else
			$display("** allocation_bitmap_engine: FAILED **");
		$finish;
	end

endmodule
